// File: src/stip_pkg.sv
// Shared types, constants and the digit decoder of the string-to-integer parser.
// No dependencies; every other file of the block imports this package.
package stip_pkg;

  localparam int MAX_CHARS  = 4096;
  localparam int POS_W      = $clog2(MAX_CHARS + 1);
  localparam int ACC_W      = 64;
  localparam int BASE_W     = 6;
  localparam int CHAR_W     = 8;
  localparam int OUT_BITS   = ACC_W + POS_W;
  localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

  localparam logic [BASE_W-1:0] BASE_RESET = BASE_W'(10);
  localparam logic [BASE_W-1:0] BASE_DEC   = BASE_W'(10);
  localparam logic [BASE_W-1:0] BASE_OCT   = BASE_W'(8);
  localparam logic [BASE_W-1:0] BASE_HEX   = BASE_W'(16);
  localparam logic [BASE_W-1:0] BASE_AUTO  = BASE_W'(0);
  localparam logic [BASE_W-1:0] BASE_UNARY = BASE_W'(1);
  localparam logic [BASE_W-1:0] BASE_MAX   = BASE_W'(36);

  localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
  localparam logic [CHAR_W-1:0] CH_UP_A  = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UP_X  = 8'h58;
  localparam logic [CHAR_W-1:0] CH_UP_Z  = 8'h5A;
  localparam logic [CHAR_W-1:0] CH_LO_A  = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LO_X  = 8'h78;
  localparam logic [CHAR_W-1:0] CH_LO_Z  = 8'h7A;
  localparam logic [CHAR_W-1:0] NO_DIGIT = 8'hFF;

  typedef enum logic [2:0] {
    PH_SPACE,
    PH_SIGNED,
    PH_ZERO,
    PH_XSEEN,
    PH_DIGITS,
    PH_DONE
  } phase_t;

  typedef struct packed {
    logic signed [ACC_W-1:0] value;
    logic [POS_W-1:0]        end_offset;
  } parse_res_t;

  function automatic logic [CHAR_W-1:0] digit_of(input logic [CHAR_W-1:0] c);
    logic [CHAR_W-1:0] d;
    d = NO_DIGIT;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      d = c - CH_ZERO;
    end else if (c >= CH_LO_A && c <= CH_LO_Z) begin
      d = c - CH_LO_A + 8'd10;
    end else if (c >= CH_UP_A && c <= CH_UP_Z) begin
      d = c - CH_UP_A + 8'd10;
    end
    return d;
  endfunction

endpackage

// File: src/string_to_integer_parser_top.sv
// Channel   Dir  Bits  Contents
// s_axis    in   8     char_code, one byte of the string; zero ends it
// m_axis    out  80    value [63:0], end_offset [76:64], zero fill [79:77]
// cfg       in   6     number_base, written when cfg_wr_en is high
//
// One byte per cycle while no zero byte waits; a zero byte sits in the input register, and
// its result then goes to the result register. The stip_core multiply-add feeds acc per byte.
// Reset (rst, synchronous) clears the parse and sets number_base to 10.
// Non-zero bytes never stall; a zero byte waits in the input register while the
// result register holds a beat that has not been taken.
// Depends on stip_pkg and stip_core.
module string_to_integer_parser_top (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [stip_pkg::CHAR_W-1:0]       s_axis_tdata,   // char_code
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [stip_pkg::OUT_DATA_W-1:0]   m_axis_tdata,   // value, end_offset, zero fill
  input  logic                              cfg_wr_en,
  input  logic [stip_pkg::BASE_W-1:0]       cfg_wr_data     // number_base
);
  import stip_pkg::*;

  logic [BASE_W-1:0] number_base;
  logic              in_valid;
  logic [CHAR_W-1:0] in_char;
  logic              out_valid;
  parse_res_t        out_res;
  parse_res_t        core_res;
  logic              out_free;
  logic              proc;
  logic              is_term;

  assign is_term       = (in_char == CH_NUL);
  assign out_free      = !out_valid || m_axis_tready;
  assign proc          = in_valid && (!is_term || out_free);
  assign s_axis_tready = !in_valid || proc;

  always_ff @(posedge clk) begin
    if (rst) begin
      number_base <= BASE_RESET;
    end else if (cfg_wr_en) begin
      number_base <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_valid <= 1'b1;
    end else if (proc) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_char <= s_axis_tdata;
    end
  end

  stip_core u_core (
    .clk         (clk),
    .rst         (rst),
    .step        (proc),
    .char_code   (in_char),
    .number_base (number_base),
    .result      (core_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (proc && is_term) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc && is_term) begin
      out_res <= core_res;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {{(OUT_DATA_W-OUT_BITS){1'b0}}, out_res.end_offset, out_res.value};

  a_term_loads_result: assert property (@(posedge clk) disable iff (rst)
    proc && is_term |=> out_valid)
    else $error("terminator beat did not load the result register");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    out_valid && !m_axis_tready |=> out_valid && $stable(out_res))
    else $error("stalled result beat changed");

  a_input_held: assert property (@(posedge clk) disable iff (rst)
    in_valid && !proc |=> in_valid && $stable(in_char))
    else $error("unprocessed input beat lost");

  a_offset_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_res.end_offset <= POS_W'(MAX_CHARS))
    else $error("end offset beyond saturation limit");

endmodule

// File: src/stip_core.sv
// Parse state of the string-to-integer parser: phase, accumulator, sign, offsets.
// Advances one byte per step; depends on stip_pkg.
module stip_core (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            step,
  input  logic [stip_pkg::CHAR_W-1:0]     char_code,
  input  logic [stip_pkg::BASE_W-1:0]     number_base,
  output stip_pkg::parse_res_t            result
);
  import stip_pkg::*;

  phase_t              phase;
  phase_t              phase_next;
  logic [ACC_W-1:0]    acc;
  logic [ACC_W-1:0]    acc_next;
  logic                is_neg;
  logic                is_neg_next;
  logic [BASE_W-1:0]   active_base;
  logic [BASE_W-1:0]   active_base_next;
  logic [POS_W-1:0]    char_pos;
  logic [POS_W-1:0]    stop_pos;
  logic [POS_W-1:0]    stop_pos_next;

  logic [POS_W-1:0]    pos_sat;
  logic [CHAR_W-1:0]   digit;
  logic                is_ws;
  logic                base_bad;
  logic                prefix_ok;
  logic [BASE_W-1:0]   base_pick;
  logic [BASE_W-1:0]   eff_base;
  logic                try_digit;
  logic                zero_prefix;
  logic                set_neg;
  logic                digit_ok;
  logic [ACC_W-1:0]    acc_mul;

  assign pos_sat = (char_pos >= POS_W'(MAX_CHARS)) ? POS_W'(MAX_CHARS) : char_pos + 1'b1;
  assign digit   = digit_of(char_code);
  assign is_ws   = (char_code == CH_SPACE) || (char_code == CH_TAB) ||
                   (char_code == CH_LF) || (char_code == CH_CR);

  assign base_bad  = (number_base == BASE_UNARY) || (number_base > BASE_MAX);
  assign prefix_ok = ((number_base == BASE_AUTO) || (number_base == BASE_HEX)) &&
                     (char_code == CH_ZERO);
  assign base_pick = (number_base == BASE_AUTO) ? BASE_DEC : number_base;

  // next phase and digit-take decision
  always_comb begin
    phase_next  = phase;
    eff_base    = active_base;
    try_digit   = 1'b0;
    zero_prefix = 1'b0;
    set_neg     = 1'b0;
    unique case (phase)
      PH_SPACE, PH_SIGNED: begin
        if (phase == PH_SPACE && is_ws) begin
          phase_next = PH_SPACE;
        end else if (phase == PH_SPACE && char_code == CH_MINUS) begin
          set_neg    = 1'b1;
          phase_next = PH_SIGNED;
        end else if (phase == PH_SPACE && char_code == CH_PLUS) begin
          phase_next = PH_SIGNED;
        end else if (base_bad) begin
          phase_next = PH_DONE;
        end else if (prefix_ok) begin
          zero_prefix = 1'b1;
          phase_next  = PH_ZERO;
        end else begin
          eff_base  = base_pick;
          try_digit = 1'b1;
        end
      end
      PH_ZERO: begin
        if (char_code == CH_LO_X || char_code == CH_UP_X) begin
          phase_next = PH_XSEEN;
        end else begin
          eff_base  = (active_base == BASE_AUTO) ? BASE_OCT : BASE_HEX;
          try_digit = 1'b1;
        end
      end
      PH_XSEEN: begin
        eff_base  = BASE_HEX;
        try_digit = 1'b1;
      end
      PH_DIGITS: begin
        try_digit = 1'b1;
      end
      PH_DONE: begin
        phase_next = PH_DONE;
      end
      default: begin
        phase_next = PH_DONE;
      end
    endcase
    if (try_digit) begin
      phase_next = (digit < {{(CHAR_W-BASE_W){1'b0}}, eff_base}) ? PH_DIGITS : PH_DONE;
    end
  end

  assign digit_ok = digit < {{(CHAR_W-BASE_W){1'b0}}, eff_base};
  assign acc_mul  = ACC_W'(acc * {{(ACC_W-BASE_W){1'b0}}, eff_base});

  // datapath next values
  always_comb begin
    acc_next         = acc;
    stop_pos_next    = stop_pos;
    active_base_next = active_base;
    is_neg_next      = is_neg || set_neg;
    if (zero_prefix) begin
      acc_next         = '0;
      stop_pos_next    = pos_sat;
      active_base_next = number_base;
    end
    if (try_digit) begin
      active_base_next = eff_base;
      if (digit_ok) begin
        acc_next      = acc_mul + {{(ACC_W-CHAR_W){1'b0}}, digit};
        stop_pos_next = pos_sat;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_SPACE;
      acc         <= '0;
      is_neg      <= 1'b0;
      active_base <= '0;
      char_pos    <= '0;
      stop_pos    <= '0;
    end else if (step) begin
      if (char_code == CH_NUL) begin
        phase       <= PH_SPACE;
        acc         <= '0;
        is_neg      <= 1'b0;
        active_base <= '0;
        char_pos    <= '0;
        stop_pos    <= '0;
      end else begin
        phase       <= phase_next;
        acc         <= acc_next;
        is_neg      <= is_neg_next;
        active_base <= active_base_next;
        char_pos    <= pos_sat;
        stop_pos    <= stop_pos_next;
      end
    end
  end

  assign result.value      = is_neg ? (ACC_W'(0) - acc) : acc;
  assign result.end_offset = stop_pos;

endmodule

// File: tb/sv/string_to_integer_parser_top_test.sv
// Self-checking testbench of string_to_integer_parser_top: strings of bytes in, parsed numbers out.
// Checks each result against an in-bench strtol-style predictor across several radix settings.
// Depends on stip_pkg and the parser RTL.
`timescale 1ns / 100ps

module string_to_integer_parser_top_test;
  import stip_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASE_BYTES    = 100;
  localparam int RANDOM_PHASES  = 12;
  localparam int HOLDOFF_CYCLES = 300;

  typedef struct {
    logic [ACC_W-1:0] value;
    logic [POS_W-1:0] offset;
  } parsed_number_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [CHAR_W-1:0]     s_axis_tdata = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  cfg_wr_en = 1'b0;
  logic [BASE_W-1:0]     cfg_wr_data = '0;

  logic [CHAR_W-1:0] pending_bytes[$];
  parsed_number_t    expected_numbers[$];

  // predictor state
  phase_t            scan_phase;
  logic [ACC_W-1:0]  scan_acc;
  bit                scan_neg;
  logic [BASE_W-1:0] scan_radix;
  logic [POS_W-1:0]  scan_pos;
  logic [POS_W-1:0]  scan_stop;
  logic [BASE_W-1:0] radix_reg = BASE_RESET;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int holdoff_req    = 0;
  int holdoff_seen   = 0;
  int holdoff_left   = 0;
  int quiet_cycles   = 0;
  int errors         = 0;
  int strings_queued = 0;
  int bytes_taken    = 0;
  int numbers_seen   = 0;
  int radix_writes   = 0;

  string_to_integer_parser_top uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic logic [CHAR_W-1:0] char_weight(input logic [CHAR_W-1:0] c);
    logic [CHAR_W-1:0] w;
    w = NO_DIGIT;
    if (c inside {[CH_ZERO:CH_NINE]}) w = c - CH_ZERO;
    if (c inside {[CH_LO_A:CH_LO_Z]}) w = 8'd10 + (c - CH_LO_A);
    if (c inside {[CH_UP_A:CH_UP_Z]}) w = 8'd10 + (c - CH_UP_A);
    return w;
  endfunction

  function automatic logic [POS_W-1:0] next_pos(input logic [POS_W-1:0] i);
    return (i >= POS_W'(MAX_CHARS)) ? POS_W'(MAX_CHARS) : i + 1'b1;
  endfunction

  task automatic clear_scan();
    scan_phase = PH_SPACE;
    scan_acc   = '0;
    scan_neg   = 1'b0;
    scan_radix = '0;
    scan_pos   = '0;
    scan_stop  = '0;
  endtask

  task automatic accumulate(input logic [CHAR_W-1:0] c, input logic [POS_W-1:0] idx);
    logic [CHAR_W-1:0] w;
    w = char_weight(c);
    if (w < CHAR_W'(scan_radix)) begin
      scan_acc   = scan_acc * ACC_W'(scan_radix) + ACC_W'(w);
      scan_stop  = next_pos(idx);
      scan_phase = PH_DIGITS;
    end else begin
      scan_phase = PH_DONE;
    end
  endtask

  task automatic begin_number(input logic [CHAR_W-1:0] c, input logic [POS_W-1:0] idx);
    if (radix_reg == BASE_UNARY || radix_reg > BASE_MAX) begin
      scan_phase = PH_DONE;
    end else if ((radix_reg == BASE_AUTO || radix_reg == BASE_HEX) && c == CH_ZERO) begin
      scan_acc   = '0;
      scan_stop  = next_pos(idx);
      scan_radix = radix_reg;
      scan_phase = PH_ZERO;
    end else begin
      scan_radix = (radix_reg == BASE_AUTO) ? BASE_DEC : radix_reg;
      accumulate(c, idx);
    end
  endtask

  task automatic parse_byte(input logic [CHAR_W-1:0] c);
    logic [POS_W-1:0] idx;
    parsed_number_t   num;
    idx = scan_pos;
    if (c == CH_NUL) begin
      num.value  = scan_neg ? -scan_acc : scan_acc;
      num.offset = scan_stop;
      expected_numbers.push_back(num);
      clear_scan();
    end else begin
      scan_pos = next_pos(idx);
      case (scan_phase)
        PH_SPACE: begin
          if (c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR) begin
          end else if (c == CH_MINUS) begin
            scan_neg   = 1'b1;
            scan_phase = PH_SIGNED;
          end else if (c == CH_PLUS) begin
            scan_phase = PH_SIGNED;
          end else begin
            begin_number(c, idx);
          end
        end
        PH_SIGNED: begin_number(c, idx);
        PH_ZERO: begin
          if (c == CH_LO_X || c == CH_UP_X) begin
            scan_phase = PH_XSEEN;
          end else begin
            scan_radix = (scan_radix == BASE_AUTO) ? BASE_OCT : BASE_HEX;
            accumulate(c, idx);
          end
        end
        PH_XSEEN: begin
          scan_radix = BASE_HEX;
          accumulate(c, idx);
        end
        PH_DIGITS: accumulate(c, idx);
        default: scan_phase = PH_DONE;
      endcase
    end
  endtask

  // driver: one beat offered at a time, predicted when taken
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        parse_byte(s_axis_tdata);
        bytes_taken++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= pending_bytes.pop_front();
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor: compare each result beat with the oldest expected number
  always @(posedge clk) begin
    parsed_number_t    want;
    logic [ACC_W-1:0]  got_value;
    logic [POS_W-1:0]  got_offset;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got_value  = m_axis_tdata[ACC_W-1:0];
        got_offset = m_axis_tdata[ACC_W +: POS_W];
        if (expected_numbers.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, value %0d offset %0d",
                   $time, $signed(got_value), got_offset);
        end else begin
          want = expected_numbers.pop_front();
          numbers_seen++;
          if (got_value !== want.value) begin
            errors++;
            $display("%0t: value mismatch, expected %0d actual %0d",
                     $time, $signed(want.value), $signed(got_value));
          end
          if (got_offset !== want.offset) begin
            errors++;
            $display("%0t: end_offset mismatch, expected %0d actual %0d",
                     $time, want.offset, got_offset);
          end
        end
      end
      if (holdoff_req != holdoff_seen) begin
        holdoff_seen = holdoff_req;
        holdoff_left = HOLDOFF_CYCLES;
      end
      if (holdoff_left > 0) begin
        holdoff_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || cfg_wr_en || (s_axis_tvalid && s_axis_tready) ||
        (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no beat moved for %0d cycles", $time, quiet_cycles);
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic push_char(input logic [CHAR_W-1:0] c);
    pending_bytes.push_back(c);
    if (c == CH_NUL) strings_queued++;
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) push_char(s[i]);
    push_char(CH_NUL);
  endtask

  function automatic logic [CHAR_W-1:0] digit_char(input int d);
    if (d < 10) return CH_ZERO + CHAR_W'(d);
    return ($urandom_range(1) ? CH_LO_A : CH_UP_A) + CHAR_W'(d - 10);
  endfunction

  function automatic logic [CHAR_W-1:0] blank_char();
    case ($urandom_range(3))
      0: return CH_SPACE;
      1: return CH_TAB;
      2: return CH_LF;
      default: return CH_CR;
    endcase
  endfunction

  // mostly well-formed numbers with random content, some raw noise
  task automatic push_random_text(input logic [BASE_W-1:0] b);
    int radix;
    int n;
    if ($urandom_range(99) < 15) begin
      n = $urandom_range(6);
      repeat (n) push_char(CHAR_W'($urandom_range(1, 255)));
    end else begin
      repeat ($urandom_range(2)) push_char(blank_char());
      case ($urandom_range(3))
        0: push_char(CH_MINUS);
        1: push_char(CH_PLUS);
        default: ;
      endcase
      radix = (b == BASE_AUTO || b == BASE_UNARY || b > BASE_MAX) ? 10 : int'(b);
      if ((b == BASE_AUTO || b == BASE_HEX) && $urandom_range(2) == 0) begin
        push_char(CH_ZERO);
        if ($urandom_range(3) != 0) begin
          push_char($urandom_range(1) ? CH_LO_X : CH_UP_X);
          radix = 16;
        end else if (b == BASE_AUTO) begin
          radix = 8;
        end
      end
      n = ($urandom_range(9) == 0) ? $urandom_range(17, 26) : $urandom_range(6);
      repeat (n) push_char(digit_char($urandom_range(radix - 1)));
      repeat ($urandom_range(2)) push_char(CHAR_W'($urandom_range(1, 255)));
    end
    push_char(CH_NUL);
  endtask

  task automatic drain();
    while (pending_bytes.size() != 0 || s_axis_tvalid || expected_numbers.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_radix(input logic [BASE_W-1:0] b);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= b;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    radix_reg = b;
    radix_writes++;
  endtask

  initial begin
    logic [BASE_W-1:0] b;
    int                goal;
    clear_scan();
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // reset radix: blanks, signs, empty and junk strings
    push_text("");
    push_text(" \t\n\r-9");
    push_text("+0");
    push_text("-");
    push_text("z7");
    push_text("12a3");
    drain();
    write_radix(BASE_AUTO);
    push_text("0x1fZ");
    push_text("0Xg");
    push_text("017");
    push_text("-09");
    drain();
    write_radix(BASE_UNARY);
    push_text("5");
    drain();
    write_radix(BASE_W'(63));
    push_text("7");
    drain();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0: b = BASE_AUTO;
        1: b = BASE_HEX;
        2: b = BASE_W'(2);
        3: b = BASE_MAX;
        4: b = BASE_OCT;
        5: b = BASE_DEC;
        6: b = BASE_UNARY;
        7: b = BASE_W'(37);
        8: b = BASE_AUTO;
        default: b = BASE_W'($urandom_range(0, 36));
      endcase
      write_radix(b);
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 84; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 84; end
        default: begin send_idle_pct = 8; recv_stall_pct = 8; end
      endcase
      if (p == 4) holdoff_req++;
      goal = pending_bytes.size() + PHASE_BYTES;
      while (pending_bytes.size() < goal) push_random_text(b);
      drain();
    end

    if (expected_numbers.size() != 0) begin
      errors++;
      $display("%0t: %0d expected results never arrived", $time, expected_numbers.size());
    end
    $display("Covered %0d strings, %0d bytes and %0d results over %0d radix writes,",
             strings_queued, bytes_taken, numbers_seen, radix_writes);
    $display("with auto, octal, hex, invalid and extreme radixes under idle and stall mixes.");
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// File: sim.f
src/stip_pkg.sv
src/stip_core.sv
src/string_to_integer_parser_top.sv
tb/sv/string_to_integer_parser_top_test.sv
